/* src/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  localparam int unsigned FULL_SCALE    = 255;
  localparam int unsigned FULL_SCALE_SQ = 65025;

  localparam logic [7:0]  FULL_SCALE_8   = 8'(FULL_SCALE);
  localparam logic [15:0] FULL_SCALE_SQ16 = 16'(FULL_SCALE_SQ);

  // Reciprocal constants, rounded up. With these shifts the product gives the
  // exact truncated quotient for every numerator that the datapath produces.
  localparam int unsigned P_RECIP_SHIFT = 24;
  localparam logic [16:0] P_RECIP =
    17'(((64'd1 << P_RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));
  localparam int unsigned Q_RECIP_SHIFT = 40;
  localparam logic [24:0] Q_RECIP =
    25'(((64'd1 << Q_RECIP_SHIFT) + 64'(FULL_SCALE_SQ) - 64'd1) / 64'(FULL_SCALE_SQ));

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  typedef struct packed {
    logic       valid;
    logic       gray;
    sector_t    sector;
    logic [7:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
  } stage1_t;

  typedef struct packed {
    logic       valid;
    logic       gray;
    sector_t    sector;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
    logic [7:0] val;
  } stage4_t;

endpackage

/* src/hsv2rgb_sector.sv */
module hsv2rgb_sector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output hsv2rgb_pkg::stage1_t  s1
);

  localparam logic [10:0] BOUND_1 = 11'(1 * hsv2rgb_pkg::FULL_SCALE);
  localparam logic [10:0] BOUND_2 = 11'(2 * hsv2rgb_pkg::FULL_SCALE);
  localparam logic [10:0] BOUND_3 = 11'(3 * hsv2rgb_pkg::FULL_SCALE);
  localparam logic [10:0] BOUND_4 = 11'(4 * hsv2rgb_pkg::FULL_SCALE);
  localparam logic [10:0] BOUND_5 = 11'(5 * hsv2rgb_pkg::FULL_SCALE);

  logic [7:0]           hue_wrapped;
  logic [10:0]          hue6;
  logic [10:0]          base;
  hsv2rgb_pkg::sector_t sector;
  logic [10:0]          rem_wide;

  // The top of the hue range is the same color as hue zero.
  assign hue_wrapped = (hsv.hue == hsv2rgb_pkg::FULL_SCALE_8) ? 8'd0 : hsv.hue;
  assign hue6 = 11'(hue_wrapped) * 11'd6;

  always_comb begin
    priority if (hue6 >= BOUND_5) begin
      sector = hsv2rgb_pkg::SEC_MAGENTA;
      base   = BOUND_5;
    end else if (hue6 >= BOUND_4) begin
      sector = hsv2rgb_pkg::SEC_BLUE;
      base   = BOUND_4;
    end else if (hue6 >= BOUND_3) begin
      sector = hsv2rgb_pkg::SEC_CYAN;
      base   = BOUND_3;
    end else if (hue6 >= BOUND_2) begin
      sector = hsv2rgb_pkg::SEC_GREEN;
      base   = BOUND_2;
    end else if (hue6 >= BOUND_1) begin
      sector = hsv2rgb_pkg::SEC_YELLOW;
      base   = BOUND_1;
    end else begin
      sector = hsv2rgb_pkg::SEC_RED;
      base   = 11'd0;
    end
  end

  assign rem_wide = hue6 - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= start;
    end
    s1.gray   <= (hsv.saturation == 8'd0);
    s1.sector <= sector;
    s1.rem    <= rem_wide[7:0];
    s1.sat    <= hsv.saturation;
    s1.val    <= hsv.brightness;
  end

endmodule

/* src/hsv2rgb_pqt.sv */
module hsv2rgb_pqt (
  input  logic                 clk,
  input  logic                 rst,
  input  hsv2rgb_pkg::stage1_t s1,
  output hsv2rgb_pkg::stage4_t s4
);

  // Second stage: products of saturation and the in-sector position, and the numerator of p.
  logic                 s2_valid;
  logic                 s2_gray;
  hsv2rgb_pkg::sector_t s2_sector;
  logic [7:0]           s2_val;
  logic [15:0]          s2_sr;
  logic [15:0]          s2_sr_inv;
  logic [15:0]          s2_p_num;

  // Third stage: numerators of q and t, p already reduced.
  logic                 s3_valid;
  logic                 s3_gray;
  hsv2rgb_pkg::sector_t s3_sector;
  logic [7:0]           s3_val;
  logic [7:0]           s3_p;
  logic [23:0]          s3_q_num;
  logic [23:0]          s3_t_num;

  logic [32:0]          p_prod;
  logic [48:0]          q_prod;
  logic [48:0]          t_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_gray   <= s1.gray;
    s2_sector <= s1.sector;
    s2_val    <= s1.val;
    s2_sr     <= 16'(s1.sat) * 16'(s1.rem);
    s2_sr_inv <= 16'(s1.sat) * 16'(hsv2rgb_pkg::FULL_SCALE_8 - s1.rem);
    s2_p_num  <= 16'(s1.val) * 16'(hsv2rgb_pkg::FULL_SCALE_8 - s1.sat);
  end

  // Division by 255 as a multiplication by the rounded-up reciprocal.
  assign p_prod = 33'(s2_p_num) * 33'(hsv2rgb_pkg::P_RECIP);

  always_ff @(posedge clk) begin
    s3_gray   <= s2_gray;
    s3_sector <= s2_sector;
    s3_val    <= s2_val;
    s3_p      <= p_prod[hsv2rgb_pkg::P_RECIP_SHIFT +: 8];
    s3_q_num  <= 24'(s2_val) * 24'(hsv2rgb_pkg::FULL_SCALE_SQ16 - s2_sr);
    s3_t_num  <= 24'(s2_val) * 24'(hsv2rgb_pkg::FULL_SCALE_SQ16 - s2_sr_inv);
  end

  // Division by 255 squared, likewise by reciprocal.
  assign q_prod = 49'(s3_q_num) * 49'(hsv2rgb_pkg::Q_RECIP);
  assign t_prod = 49'(s3_t_num) * 49'(hsv2rgb_pkg::Q_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else begin
      s4.valid <= s3_valid;
    end
    s4.gray   <= s3_gray;
    s4.sector <= s3_sector;
    s4.val    <= s3_val;
    s4.p      <= s3_p;
    s4.q      <= q_prod[hsv2rgb_pkg::Q_RECIP_SHIFT +: 8];
    s4.t      <= t_prod[hsv2rgb_pkg::Q_RECIP_SHIFT +: 8];
  end

endmodule

/* src/hsv2rgb_select.sv */
module hsv2rgb_select (
  input  logic                  clk,
  input  logic                  rst,
  input  hsv2rgb_pkg::stage4_t  s4,
  output logic                  strobe,
  output hsv2rgb_pkg::rgb_out_t rgb
);

  hsv2rgb_pkg::rgb_out_t rgb_next;

  always_comb begin
    if (s4.gray) begin
      rgb_next = '{red: s4.val, green: s4.val, blue: s4.val};
    end else begin
      unique case (s4.sector)
        hsv2rgb_pkg::SEC_RED:    rgb_next = '{red: s4.val, green: s4.t,   blue: s4.p};
        hsv2rgb_pkg::SEC_YELLOW: rgb_next = '{red: s4.q,   green: s4.val, blue: s4.p};
        hsv2rgb_pkg::SEC_GREEN:  rgb_next = '{red: s4.p,   green: s4.val, blue: s4.t};
        hsv2rgb_pkg::SEC_CYAN:   rgb_next = '{red: s4.p,   green: s4.q,   blue: s4.val};
        hsv2rgb_pkg::SEC_BLUE:   rgb_next = '{red: s4.t,   green: s4.p,   blue: s4.val};
        default:                 rgb_next = '{red: s4.val, green: s4.p,   blue: s4.q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s4.valid;
    end
  end

  always_ff @(posedge clk) begin
    rgb <= rgb_next;
  end

endmodule

/* src/hsv_to_rgb_converter.sv */
// HSV to RGB color converter, 8 bits per component.
//
// Input channel: drive hsv and raise start for one cycle per pixel. A pixel
// transfer happens at each rising edge with start high and busy low. busy is
// always low, so a new pixel may be sent in every cycle.
// Output channel: each result appears on rgb for exactly one cycle, marked by
// strobe high. The receiver cannot stall, so no back pressure exists.
//
// Throughput is one pixel per clock. The pipeline is sector decode,
// saturation products, value products with the division of p, division of q
// and t by reciprocal multiplication, and the sector select into the output
// register. Results leave in the order the pixels came in.
//
// Synchronous reset clears all stage valid bits, so no strobe is raised for
// anything in flight at reset. The data registers are not reset.
module hsv_to_rgb_converter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  hsv2rgb_pkg::hsv_in_t  hsv,
  output logic                  strobe,
  output hsv2rgb_pkg::rgb_out_t rgb
);

  hsv2rgb_pkg::stage1_t s1;
  hsv2rgb_pkg::stage4_t s4;

  assign busy = 1'b0;

  hsv2rgb_sector u_sector (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hsv   (hsv),
    .s1    (s1)
  );

  hsv2rgb_pqt u_pqt (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s4  (s4)
  );

  hsv2rgb_select u_select (
    .clk    (clk),
    .rst    (rst),
    .s4     (s4),
    .strobe (strobe),
    .rgb    (rgb)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_PIXELS = 650;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;

  // Keeps the colors still owed by the converter, oldest first, and checks
  // every strobed result against them.
  class color_scoreboard;
    rgb_out_t expected_rgb[$];
    int       mismatches;
    int       checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    function automatic logic [7:0] clamp8(int unsigned x);
      return (x > FULL_SCALE) ? FULL_SCALE_8 : 8'(x);
    endfunction

    function automatic rgb_out_t convert_hsv(hsv_in_t px);
      int unsigned h, s, v, h6, frac, p, q, t, rd, gr, bl;
      sector_t     sec;
      rgb_out_t    c;
      h = px.hue;
      s = px.saturation;
      v = px.brightness;
      if (s == 0) begin
        rd = v;
        gr = v;
        bl = v;
      end else begin
        // The top hue code lands on the same spot as hue zero.
        if (h >= FULL_SCALE) h = 0;
        h6   = 6 * h;
        sec  = sector_t'(h6 / FULL_SCALE);
        frac = h6 % FULL_SCALE;
        p = (v * (FULL_SCALE - s)) / FULL_SCALE;
        q = (v * (FULL_SCALE_SQ - s * frac)) / FULL_SCALE_SQ;
        t = (v * (FULL_SCALE_SQ - s * (FULL_SCALE - frac))) / FULL_SCALE_SQ;
        case (sec)
          SEC_RED: begin
            rd = v; gr = t; bl = p;
          end
          SEC_YELLOW: begin
            rd = q; gr = v; bl = p;
          end
          SEC_GREEN: begin
            rd = p; gr = v; bl = t;
          end
          SEC_CYAN: begin
            rd = p; gr = q; bl = v;
          end
          SEC_BLUE: begin
            rd = t; gr = p; bl = v;
          end
          default: begin
            rd = v; gr = p; bl = q;
          end
        endcase
      end
      c.red   = clamp8(rd);
      c.green = clamp8(gr);
      c.blue  = clamp8(bl);
      return c;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    function void note_pixel(hsv_in_t px);
      expected_rgb = {expected_rgb, convert_hsv(px)};
    endfunction

    task check_pixel(rgb_out_t got);
      rgb_out_t want;
      checked++;
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected color %h", got));
      end else begin
        want = expected_rgb.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.blue));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  hsv_in_t  hsv;
  logic     strobe;
  rgb_out_t rgb;

  color_scoreboard sb;
  int              pixels_sent;
  int              cycle_count = 0;

  always #5 clk = ~clk;

  hsv_to_rgb_converter uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .hsv    (hsv),
    .strobe (strobe),
    .rgb    (rgb)
  );

  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) sb.check_pixel(rgb);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Holds start high until the converter takes the pixel. start is left high,
  // so back-to-back transfers need no extra assignment.
  task automatic send_hsv(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v);
    hsv_in_t px;
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    hsv   <= px;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    hsv   <= hsv_in_t'(24'($urandom));
    repeat (n) @(posedge clk);
  endtask

  // Mostly uniform, with the field extremes mixed in often.
  function automatic logic [7:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(0, 1));
      3: return 8'($urandom_range(254, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    int gap;
    sb          = new();
    pixels_sent = 0;
    rst   = 1'b1;
    start = 1'b0;
    hsv   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Gray inputs, the hue wrap, and both ends of every sector.
    send_hsv(8'd0,   8'd0,   8'd0);
    send_hsv(8'd255, 8'd0,   8'd200);
    send_hsv(8'd128, 8'd0,   8'd255);
    send_hsv(8'd0,   8'd255, 8'd255);
    send_hsv(8'd255, 8'd255, 8'd255);
    send_hsv(8'd42,  8'd255, 8'd255);
    send_hsv(8'd43,  8'd255, 8'd255);
    send_hsv(8'd84,  8'd255, 8'd200);
    send_hsv(8'd85,  8'd255, 8'd200);
    send_hsv(8'd127, 8'd255, 8'd255);
    send_hsv(8'd128, 8'd255, 8'd255);
    send_hsv(8'd169, 8'd200, 8'd255);
    send_hsv(8'd170, 8'd200, 8'd255);
    send_hsv(8'd212, 8'd255, 8'd255);
    send_hsv(8'd213, 8'd255, 8'd255);
    send_hsv(8'd254, 8'd255, 8'd255);
    send_hsv(8'd1,   8'd1,   8'd255);
    send_hsv(8'd100, 8'd1,   8'd1);
    send_hsv(8'd200, 8'd255, 8'd0);
    send_hsv(8'd30,  8'd128, 8'd128);
    send_hsv(8'd150, 8'd77,  8'd255);
    send_hsv(8'd240, 8'd255, 8'd1);
    pause_sender(3);

    // Random pixels in bursts; some bursts run straight into the next one.
    while (pixels_sent < RANDOM_PIXELS + 22) begin
      burst = $urandom_range(1, 24);
      repeat (burst) send_hsv(pick_field(), pick_field(), pick_field());
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) pause_sender(gap);
    end
    start <= 1'b0;

    while (sb.expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels, including gray, wrapped hue and every sector edge;",
             pixels_sent);
    $display("%0d colors compared, %0d field mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
src/hsv2rgb_pkg.sv
src/hsv2rgb_sector.sv
src/hsv2rgb_pqt.sv
src/hsv2rgb_select.sv
src/hsv_to_rgb_converter.sv
tb/sv/tb.sv
